### sv/hbnf_pkg.sv
// ----------------------------------------------------------------------------
// hbnf_pkg
// Shared types and constants for the half-block nibble framebuffer: word
// layouts, item kinds, register indexes, and controller/datapath interface.
// ----------------------------------------------------------------------------
package hbnf_pkg;

    localparam int DEF_MAX_COLUMNS   = 128;
    localparam int DEF_MAX_CELL_ROWS = 32;

    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 1'd1;

    localparam logic [7:0] WIDTH_RESET  = 8'd80;
    localparam logic [6:0] HEIGHT_RESET = 7'd48;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
    localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [3:0]         pixel_color;
    } t_in_word;

    typedef struct packed {
        logic [3:0] upper_color;
        logic [3:0] lower_color;
        logic       in_range;
    } t_out_word;

    typedef struct packed {
        logic load_item;
        logic calc;
        logic mem_read;
        logic rmw_write;
        logic out_load;
        logic sweep_step;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       sweep_done;
        logic       out_free;
    } t_dp_status;

endpackage

### sv/hbnf_ctrl.sv
// ----------------------------------------------------------------------------
// hbnf_ctrl
// Sequencer for the framebuffer: post-reset clearing sweep, item decode,
// read-modify-write, read result hand-off and clear sweep.
// ----------------------------------------------------------------------------
module hbnf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  hbnf_pkg::t_dp_status i_status,
    output logic                 o_in_stall,
    output hbnf_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CALC   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_MODIFY = 3'd4;
    localparam logic [2:0] S_SWEEP  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load_item = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                priority if (i_status.kind == hbnf_pkg::KIND_SET ||
                             i_status.kind == hbnf_pkg::KIND_READ) begin
                    n_state = S_READ;
                end else if (i_status.kind == hbnf_pkg::KIND_CLEAR) begin
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_MODIFY;
            end
            S_MODIFY: begin
                if (i_status.kind == hbnf_pkg::KIND_SET) begin
                    o_cmd.rmw_write = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### sv/hbnf_datapath.sv
// ----------------------------------------------------------------------------
// hbnf_datapath
// Configuration registers, address computation, cell store, nibble merge,
// fill sweep counter and result register.
// ----------------------------------------------------------------------------
module hbnf_datapath #(
    parameter int MAX_COLUMNS   = hbnf_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_CELL_ROWS = hbnf_pkg::DEF_MAX_CELL_ROWS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hbnf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [hbnf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  hbnf_pkg::t_in_word                 i_in_data,
    input  logic                               i_out_stall,
    input  hbnf_pkg::t_dp_cmd                  i_cmd,
    output hbnf_pkg::t_dp_status               o_status,
    output logic                               o_out_valid,
    output hbnf_pkg::t_out_word                o_out_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_CELL_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = AW + 1;

    logic [7:0]         r_canvas_width;
    logic [6:0]         r_canvas_height;
    hbnf_pkg::t_in_word r_item;

    logic [7:0]         w_eff_w;
    logic [5:0]         w_half_h;
    logic [5:0]         w_eff_rows;
    logic [15:0]        w_row_sel;
    logic               w_hit;
    logic [13:0]        w_row_base;
    logic [13:0]        w_cell_idx;
    logic [13:0]        w_cell_cnt;

    logic [AW-1:0]      r_addr;
    logic               r_hit;
    logic               r_lower;
    logic [AW-1:0]      r_sweep_addr;
    logic [NW-1:0]      r_sweep_end;
    logic [7:0]         r_fill;
    logic [7:0]         r_rd_data;
    logic               r_out_valid;
    hbnf_pkg::t_out_word r_out_data;

    logic [7:0]         mem [0:DEPTH-1];
    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic [7:0]         w_wd;
    logic               w_sweep_in;
    logic [7:0]         w_merged;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= hbnf_pkg::WIDTH_RESET;
            r_canvas_height <= hbnf_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hbnf_pkg::CFG_IDX_WIDTH:  r_canvas_width  <= i_cfg_data;
                hbnf_pkg::CFG_IDX_HEIGHT: r_canvas_height <= i_cfg_data[6:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
    end

    assign w_eff_w    = (32'(r_canvas_width) < MAX_COLUMNS) ? r_canvas_width
                                                            : 8'(MAX_COLUMNS);
    assign w_half_h   = r_canvas_height[6:1];
    assign w_eff_rows = (32'(w_half_h) < MAX_CELL_ROWS) ? w_half_h
                                                        : 6'(MAX_CELL_ROWS);
    assign w_row_sel  = (r_item.kind == hbnf_pkg::KIND_SET)
                      ? {1'b0, r_item.pos_y[15:1]} : r_item.pos_y;
    assign w_hit      = !r_item.pos_x[15] && !r_item.pos_y[15]
                      && (r_item.pos_x < $signed({8'd0, w_eff_w}))
                      && (w_row_sel < {10'd0, w_eff_rows});
    assign w_row_base = w_row_sel[5:0] * w_eff_w;
    assign w_cell_idx = w_row_base + {6'd0, r_item.pos_x[7:0]};
    assign w_cell_cnt = w_eff_rows * w_eff_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_addr  <= AW'(w_cell_idx);
            r_hit   <= w_hit;
            r_lower <= r_item.pos_y[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_sweep_end  <= NW'(DEPTH);
            r_fill       <= '0;
        end else if (i_cmd.calc) begin
            r_sweep_addr <= '0;
            r_sweep_end  <= NW'(w_cell_cnt);
            r_fill       <= {r_item.pixel_color, r_item.pixel_color};
        end else if (i_cmd.sweep_step) begin
            r_sweep_addr <= r_sweep_addr + 1'b1;
        end
    end

    assign w_sweep_in          = ({1'b0, r_sweep_addr} < r_sweep_end);
    assign o_status.sweep_done = (({1'b0, r_sweep_addr} + 1'b1) >= r_sweep_end);
    assign o_status.kind       = r_item.kind;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign w_merged = r_lower
        ? ((r_rd_data & hbnf_pkg::HIGH_NIBBLE) | {4'd0, r_item.pixel_color})
        : ({r_item.pixel_color, 4'd0} | (r_rd_data & hbnf_pkg::LOW_NIBBLE));

    always_comb begin
        if (i_cmd.sweep_step) begin
            w_we = w_sweep_in;
            w_wa = r_sweep_addr;
            w_wd = r_fill;
        end else begin
            w_we = i_cmd.rmw_write && r_hit;
            w_wa = r_addr;
            w_wd = w_merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (i_cmd.mem_read) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.upper_color <= r_hit ? r_rd_data[7:4] : 4'd0;
            r_out_data.lower_color <= r_hit ? r_rd_data[3:0] : 4'd0;
            r_out_data.in_range    <= r_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### sv/half_block_nibble_framebuffer.sv
// ----------------------------------------------------------------------------
// half_block_nibble_framebuffer
// Character-cell framebuffer holding two stacked 4-bit pixels per cell.
// ----------------------------------------------------------------------------
//  channel  | handshake               | word
//  ---------+-------------------------+--------------------------------------
//  in       | i_in_valid / o_in_stall | kind, pos_x, pos_y, pixel_color
//  out      | o_out_valid/ i_out_stall| upper_color, lower_color, in_range
//  config   | i_cfg_we                | i_cfg_index, i_cfg_data
//
//  Set and read step through decode, address multiply, store read, then merge (set) or result load (read).
//  Clear sweeps width*rows cells, one cell per cycle on the store port.
//  After reset all MAX_COLUMNS*MAX_CELL_ROWS cells (4096 by default) of the
//  store are swept to zero with o_in_stall high.
//  A pending read result does not block input; a read waits at its last
//  cycle only while the result register is still full and stalled.
// ----------------------------------------------------------------------------
module half_block_nibble_framebuffer #(
    parameter int MAX_COLUMNS   = hbnf_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_CELL_ROWS = hbnf_pkg::DEF_MAX_CELL_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hbnf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hbnf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  hbnf_pkg::t_in_word               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output hbnf_pkg::t_out_word              o_out_data
);

    hbnf_pkg::t_dp_cmd    w_cmd;
    hbnf_pkg::t_dp_status w_status;

    hbnf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    hbnf_datapath #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_CELL_ROWS (MAX_CELL_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.sweep_step && w_cmd.rmw_write))
        else $error("sweep and read-modify-write share the store port");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_status.out_free)
        else $error("result register loaded while a word is still held");

    a_decode_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (w_cmd.calc && o_in_stall))
        else $error("accepted word not decoded in the next cycle");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

endmodule
